// ----- rtl/strip_shape_rasterizer_assert.svh -----
// -----------------------------------------------------------------------------
// Assertion macros for the strip shape rasterizer
// Clocked on clk_i, disabled while rst_ni is low.
// -----------------------------------------------------------------------------
`ifndef STRIP_SHAPE_RASTERIZER_ASSERT_SVH
`define STRIP_SHAPE_RASTERIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SSR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ssr assertion failed");
`define SSR_ASSERT_NEVER(lbl, prop) \
  `SSR_ASSERT(lbl, !(prop))
`else
`define SSR_ASSERT(lbl, prop)
`define SSR_ASSERT_NEVER(lbl, prop)
`endif

`endif

// ----- rtl/ssr_pkg.sv -----
// -----------------------------------------------------------------------------
// ssr_pkg
// Shared constants, codes and types of the strip shape rasterizer.
// -----------------------------------------------------------------------------
`default_nettype none

package ssr_pkg;

  localparam int STRIP_COLUMNS  = 16;
  localparam int COLUMN_HEIGHT  = 320;
  localparam int RING_THICKNESS = 3;
  localparam int STORE_DEPTH    = STRIP_COLUMNS * COLUMN_HEIGHT;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int COL_IDX_W      = (STRIP_COLUMNS > 1) ? $clog2(STRIP_COLUMNS) : 1;
  localparam int COL_CNT_W      = $clog2(STRIP_COLUMNS + 1);
  localparam int ROW_CNT_W      = $clog2(COLUMN_HEIGHT + 1);
  localparam int PIX_W          = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_WIDTH = 1'b1;

  typedef enum logic [2:0] {
    MODE_RECT_FILL = 3'd0,
    MODE_RECT_LINE = 3'd1,
    MODE_ELL_FILL  = 3'd2,
    MODE_ELL_RING  = 3'd3,
    MODE_READ      = 3'd4
  } mode_e;

  // classified word handed from front to back
  typedef struct packed {
    mode_e                  mode;
    logic                   in_strip;     // reads: position lies in the strip
    logic [COL_CNT_W-1:0]   c_lo;         // first strip column (read column)
    logic [COL_CNT_W-1:0]   c_hi;         // one past last strip column
    logic [ROW_CNT_W-1:0]   r_lo;         // first row (read row)
    logic [ROW_CNT_W-1:0]   r_hi;         // one past last row
    logic [15:0]            strip_start;
    logic [15:0]            x_ref;        // rect corner or ellipse centre
    logic [16:0]            x_last;       // rect last column
    logic [15:0]            y_ref;
    logic [16:0]            y_last;
    logic [14:0]            rx;
    logic [14:0]            ry;
    logic [PIX_W-1:0]       color;
  } cmd_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RECT,
    ST_SETUP_A,
    ST_SETUP_B,
    ST_SETUP_C,
    ST_SETUP_A3,
    ST_SETUP_B3,
    ST_SETUP_C3,
    ST_COL_DX,
    ST_COL_PB,
    ST_COL_PB3,
    ST_ROW_DY,
    ST_ROW_QA,
    ST_ROW_QA3,
    ST_EVAL,
    ST_READ,
    ST_RDATA
  } back_state_e;

endpackage

`default_nettype wire

// ----- rtl/ssr_if.sv -----
// -----------------------------------------------------------------------------
// ssr interfaces
// Valid/ready channels: draw/read input, pixel result and register writes.
// -----------------------------------------------------------------------------
`default_nettype none

interface ssr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] x_pos;
  logic [15:0] y_pos;
  logic [15:0] span_x;
  logic [15:0] span_y;
  logic [15:0] color;
  logic        centered;

  modport source (output valid, mode, x_pos, y_pos, span_x, span_y, color, centered,
                  input ready);
  modport sink   (input valid, mode, x_pos, y_pos, span_x, span_y, color, centered,
                  output ready);
endinterface

interface ssr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_color;
  logic        in_strip;

  modport source (output valid, pixel_color, in_strip, input ready);
  modport sink   (input valid, pixel_color, in_strip, output ready);
endinterface

interface ssr_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/strip_shape_rasterizer.sv -----
// -----------------------------------------------------------------------------
// strip_shape_rasterizer
// Draws rectangles, outlines, ellipses and ellipse rings into a 16 x 320
// column-major pixel strip and reads single pixels back.
//
// After reset the block zeroes its pixel store, one pixel per cycle; input
// words are held off meanwhile, register writes are taken at any time. Each
// draw is clipped to the strip and to rows 0..319 when it is accepted, then
// queued (two words deep) for the back end, which visits the clipped box one
// pixel at a time. Ellipses are tested on the single 32x32 multiplier, shared
// across the test's steps, with extra steps for the inner edge of rings.
// Empty draws and unused modes are dropped on the spot. A read is served
// behind earlier draws, and its result waits in an output register.
// -----------------------------------------------------------------------------
`default_nettype none

module strip_shape_rasterizer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ssr_in_if.sink    in_i,
  ssr_cfg_if.sink   cfg_i,
  ssr_out_if.source out_o
);
  import ssr_pkg::*;

  logic push, pop, full, empty, clear_busy;
  cmd_t cmd, head;

  ssr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .clear_busy_i (clear_busy),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (cmd)
  );

  ssr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  ssr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .clear_busy_o (clear_busy),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// ----- rtl/ssr_ram.sv -----
// -----------------------------------------------------------------------------
// ssr_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
`default_nettype none

module ssr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/ssr_front.sv -----
// -----------------------------------------------------------------------------
// ssr_front
// Takes input words and register writes, clips each shape to the strip and
// hands a classified command word to the queue.
// -----------------------------------------------------------------------------
`default_nettype none

module ssr_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ssr_in_if.sink           in_i,
  ssr_cfg_if.sink          cfg_i,
  input  wire logic        clear_busy_i,
  input  wire logic        full_i,
  output      logic        push_o,
  output      ssr_pkg::cmd_t cmd_o
);
  import ssr_pkg::*;

  logic [15:0]          strip_start_q, strip_start_d;
  logic [4:0]           strip_width_q, strip_width_d;
  logic [COL_CNT_W-1:0] w;
  logic [15:0]          sx_h, sy_h, cxr, cyr, cxe, cye;
  logic                 is_rect, x_ok, y_ok, rd_in, push_ok;
  logic signed [19:0]   xa, xb, ya, yb, s0, s1, xlo, xhi, ylo, yhi, hgt, xp, yp;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_comb begin
    strip_start_d = strip_start_q;
    strip_width_d = strip_width_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_STRIP_START: strip_start_d = cfg_i.data;
        CFG_STRIP_WIDTH: strip_width_d = cfg_i.data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_start_q <= 16'd0;
      strip_width_q <= 5'd16;
    end else begin
      strip_start_q <= strip_start_d;
      strip_width_q <= strip_width_d;
    end
  end

  // used width, saturated to the stored columns
  always_comb begin
    if (int'(strip_width_q) > STRIP_COLUMNS) begin
      w = COL_CNT_W'(STRIP_COLUMNS);
    end else begin
      w = COL_CNT_W'(strip_width_q);
    end
  end

  // bounding box and clip
  always_comb begin
    sx_h    = {1'b0, in_i.span_x[15:1]};
    sy_h    = {1'b0, in_i.span_y[15:1]};
    cxr     = in_i.centered ? in_i.x_pos - sx_h : in_i.x_pos;
    cyr     = in_i.centered ? in_i.y_pos - sy_h : in_i.y_pos;
    cxe     = in_i.centered ? in_i.x_pos : in_i.x_pos + sx_h;
    cye     = in_i.centered ? in_i.y_pos : in_i.y_pos + sy_h;
    is_rect = (in_i.mode == MODE_RECT_FILL) || (in_i.mode == MODE_RECT_LINE);
    if (is_rect) begin
      xa = $signed({4'b0, cxr});
      xb = $signed({4'b0, cxr}) + $signed({4'b0, in_i.span_x});
      ya = $signed({4'b0, cyr});
      yb = $signed({4'b0, cyr}) + $signed({4'b0, in_i.span_y});
    end else begin
      xa = $signed({4'b0, cxe}) - $signed({4'b0, sx_h});
      xb = $signed({4'b0, cxe}) + $signed({4'b0, sx_h});
      ya = $signed({4'b0, cye}) - $signed({4'b0, sy_h});
      yb = $signed({4'b0, cye}) + $signed({4'b0, sy_h});
    end
    s0   = $signed({4'b0, strip_start_q});
    s1   = s0 + $signed(20'(w));
    hgt  = $signed(20'(COLUMN_HEIGHT));
    xlo  = (xa > s0) ? xa : s0;
    xhi  = (xb < s1) ? xb : s1;
    ylo  = (ya > 20'sd0) ? ya : 20'sd0;
    yhi  = (yb < hgt) ? yb : hgt;
    x_ok = xlo < xhi;
    y_ok = ylo < yhi;
    xp   = $signed({4'b0, in_i.x_pos});
    yp   = $signed({4'b0, in_i.y_pos});
    rd_in = (xp >= s0) && (xp < s1) && (yp < hgt);
  end

  // command word
  always_comb begin
    cmd_o.mode        = mode_e'(in_i.mode);
    cmd_o.in_strip    = rd_in;
    cmd_o.strip_start = strip_start_q;
    cmd_o.x_ref       = is_rect ? cxr : cxe;
    cmd_o.y_ref       = is_rect ? cyr : cye;
    cmd_o.x_last      = 17'(xb - 20'sd1);
    cmd_o.y_last      = 17'(yb - 20'sd1);
    cmd_o.rx          = sx_h[14:0];
    cmd_o.ry          = sy_h[14:0];
    cmd_o.color       = in_i.color;
    if (in_i.mode == MODE_READ) begin
      cmd_o.c_lo = COL_CNT_W'(xp - s0);
      cmd_o.c_hi = COL_CNT_W'(xp - s0);
      cmd_o.r_lo = ROW_CNT_W'(in_i.y_pos);
      cmd_o.r_hi = ROW_CNT_W'(in_i.y_pos);
    end else begin
      cmd_o.c_lo = COL_CNT_W'(xlo - s0);
      cmd_o.c_hi = COL_CNT_W'(xhi - s0);
      cmd_o.r_lo = ROW_CNT_W'(ylo);
      cmd_o.r_hi = ROW_CNT_W'(yhi);
    end
  end

  // classify: reads always go on, empty draws and unused modes are dropped
  always_comb begin
    unique case (in_i.mode)
      MODE_READ:                                      push_ok = 1'b1;
      MODE_RECT_FILL, MODE_RECT_LINE,
      MODE_ELL_FILL, MODE_ELL_RING:                   push_ok = x_ok && y_ok;
      default:                                        push_ok = 1'b0;
    endcase
  end

  assign in_i.ready = !full_i && !clear_busy_i;
  assign push_o     = in_i.valid && in_i.ready && push_ok;

endmodule

`default_nettype wire

// ----- rtl/ssr_queue.sv -----
// -----------------------------------------------------------------------------
// ssr_queue
// Short command queue between the front and the back.
// -----------------------------------------------------------------------------
`default_nettype none

module ssr_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ssr_pkg::cmd_t cmd_i,
  input  wire logic          pop_i,
  output      ssr_pkg::cmd_t head_o,
  output      logic          full_o,
  output      logic          empty_o
);
  import ssr_pkg::*;

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rptr_q];

  // payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (int'(wptr_q) == QUEUE_DEPTH - 1) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (int'(rptr_q) == QUEUE_DEPTH - 1) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ssr_back.sv -----
// -----------------------------------------------------------------------------
// ssr_back
// Executes queued commands: scans the clipped box, runs the ellipse test on
// one shared multiplier, writes the pixel store and answers reads.
// -----------------------------------------------------------------------------
`default_nettype none
`include "strip_shape_rasterizer_assert.svh"

module ssr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ssr_pkg::cmd_t head_i,
  input  wire logic          empty_i,
  output      logic          pop_o,
  output      logic          clear_busy_o,
  ssr_out_if.source          out_o
);
  import ssr_pkg::*;

  back_state_e          state_q, state_d;
  cmd_t                 cmd_q, cmd_d;
  logic [COL_CNT_W-1:0] col_q, col_d;
  logic [ROW_CNT_W-1:0] row_q, row_d;
  logic [ADDR_W-1:0]    clr_q, clr_d;
  logic [31:0]          a_q, b_q, a3_q, b3_q, dx2_q, dy2_q;
  logic [63:0]          c_q, c3_q, pb_q, pb3_q, qa_q, qa3_q;
  logic                 out_valid_q;
  logic [PIX_W-1:0]     out_color_q;
  logic                 out_in_q;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, pix_addr;
  logic [PIX_W-1:0]     ram_wdata, ram_rdata;
  logic [31:0]          mul_a, mul_b;
  logic [63:0]          mul_p;
  logic [16:0]          x_abs, y_abs;
  logic signed [18:0]   dx, dy;
  logic signed [16:0]   rx3, ry3;
  logic [15:0]          dx_mag, dy_mag, rx3_mag, ry3_mag;
  logic signed [65:0]   f_out, f_in;
  logic                 ring, rect_hit, ell_hit, last_row, last_col;

  ssr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (pix_addr),
    .rdata_o (ram_rdata)
  );

  // pixel position and distances to the centre
  always_comb begin
    x_abs    = {1'b0, cmd_q.strip_start} + 17'(col_q);
    y_abs    = 17'(row_q);
    pix_addr = ADDR_W'(col_q[COL_IDX_W-1:0]) * ADDR_W'(COLUMN_HEIGHT) + ADDR_W'(row_q);
    dx       = $signed({3'b0, cmd_q.x_ref}) - $signed({2'b0, x_abs});
    dy       = $signed({3'b0, cmd_q.y_ref}) - $signed({2'b0, y_abs});
    rx3      = $signed({2'b0, cmd_q.rx}) - 17'(RING_THICKNESS);
    ry3      = $signed({2'b0, cmd_q.ry}) - 17'(RING_THICKNESS);
    dx_mag   = 16'((dx < 0) ? -dx : dx);
    dy_mag   = 16'((dy < 0) ? -dy : dy);
    rx3_mag  = 16'((rx3 < 0) ? -rx3 : rx3);
    ry3_mag  = 16'((ry3 < 0) ? -ry3 : ry3);
    ring     = (cmd_q.mode == MODE_ELL_RING);
    last_row = (ROW_CNT_W'(row_q + 1'b1) == cmd_q.r_hi);
    last_col = (COL_CNT_W'(col_q + 1'b1) == cmd_q.c_hi);
  end

  // rectangle test: the box is already clipped, outline keeps the edges
  assign rect_hit = (cmd_q.mode == MODE_RECT_FILL) ||
                    (x_abs == {1'b0, cmd_q.x_ref}) || (x_abs == cmd_q.x_last) ||
                    (y_abs == {1'b0, cmd_q.y_ref}) || (y_abs == cmd_q.y_last);

  // ellipse forms, outer and inner
  always_comb begin
    f_out   = $signed({2'b0, qa_q}) + $signed({2'b0, pb_q}) - $signed({2'b0, c_q});
    f_in    = $signed({2'b0, qa3_q}) + $signed({2'b0, pb3_q}) - $signed({2'b0, c3_q});
    ell_hit = (f_out < 0) && (!ring || (f_in > 0));
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SETUP_A:  begin mul_a = 32'(cmd_q.rx); mul_b = 32'(cmd_q.rx); end
      ST_SETUP_B:  begin mul_a = 32'(cmd_q.ry); mul_b = 32'(cmd_q.ry); end
      ST_SETUP_C:  begin mul_a = a_q;           mul_b = b_q;           end
      ST_SETUP_A3: begin mul_a = 32'(rx3_mag);  mul_b = 32'(rx3_mag);  end
      ST_SETUP_B3: begin mul_a = 32'(ry3_mag);  mul_b = 32'(ry3_mag);  end
      ST_SETUP_C3: begin mul_a = a3_q;          mul_b = b3_q;          end
      ST_COL_DX:   begin mul_a = 32'(dx_mag);   mul_b = 32'(dx_mag);   end
      ST_COL_PB:   begin mul_a = dx2_q;         mul_b = b_q;           end
      ST_COL_PB3:  begin mul_a = dx2_q;         mul_b = b3_q;          end
      ST_ROW_DY:   begin mul_a = 32'(dy_mag);   mul_b = 32'(dy_mag);   end
      ST_ROW_QA:   begin mul_a = dy2_q;         mul_b = a_q;           end
      ST_ROW_QA3:  begin mul_a = dy2_q;         mul_b = a3_q;          end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // product registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_SETUP_A:  a_q   <= mul_p[31:0];
      ST_SETUP_B:  b_q   <= mul_p[31:0];
      ST_SETUP_C:  c_q   <= mul_p;
      ST_SETUP_A3: a3_q  <= mul_p[31:0];
      ST_SETUP_B3: b3_q  <= mul_p[31:0];
      ST_SETUP_C3: c3_q  <= mul_p;
      ST_COL_DX:   dx2_q <= mul_p[31:0];
      ST_COL_PB:   pb_q  <= mul_p;
      ST_COL_PB3:  pb3_q <= mul_p;
      ST_ROW_DY:   dy2_q <= mul_p[31:0];
      ST_ROW_QA:   qa_q  <= mul_p;
      ST_ROW_QA3:  qa3_q <= mul_p;
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    col_d        = col_q;
    row_d        = row_q;
    clr_d        = clr_q;
    pop_o        = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = pix_addr;
    ram_wdata    = cmd_q.color;
    clear_busy_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        clear_busy_o = 1'b1;
        ram_we       = 1'b1;
        ram_waddr    = clr_q;
        ram_wdata    = '0;
        clr_d        = clr_q + 1'b1;
        if (int'(clr_q) == STORE_DEPTH - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!empty_i && (head_i.mode != MODE_READ || !out_valid_q)) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          col_d = head_i.c_lo;
          row_d = head_i.r_lo;
          unique case (head_i.mode)
            MODE_READ:                     state_d = ST_READ;
            MODE_ELL_FILL, MODE_ELL_RING:  state_d = ST_SETUP_A;
            default:                       state_d = ST_RECT;
          endcase
        end
      end
      ST_SETUP_A:  state_d = ST_SETUP_B;
      ST_SETUP_B:  state_d = ST_SETUP_C;
      ST_SETUP_C:  state_d = ring ? ST_SETUP_A3 : ST_COL_DX;
      ST_SETUP_A3: state_d = ST_SETUP_B3;
      ST_SETUP_B3: state_d = ST_SETUP_C3;
      ST_SETUP_C3: state_d = ST_COL_DX;
      ST_COL_DX:   state_d = ST_COL_PB;
      ST_COL_PB:   state_d = ring ? ST_COL_PB3 : ST_ROW_DY;
      ST_COL_PB3:  state_d = ST_ROW_DY;
      ST_ROW_DY:   state_d = ST_ROW_QA;
      ST_ROW_QA:   state_d = ring ? ST_ROW_QA3 : ST_EVAL;
      ST_ROW_QA3:  state_d = ST_EVAL;
      ST_RECT, ST_EVAL: begin
        ram_we = (state_q == ST_RECT) ? rect_hit : ell_hit;
        if (!last_row) begin
          row_d   = row_q + 1'b1;
          state_d = (state_q == ST_RECT) ? ST_RECT : ST_ROW_DY;
        end else if (!last_col) begin
          row_d   = cmd_q.r_lo;
          col_d   = col_q + 1'b1;
          state_d = (state_q == ST_RECT) ? ST_RECT : ST_COL_DX;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_READ:  state_d = ST_RDATA;
      ST_RDATA: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_RDATA) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RDATA) begin
      out_color_q <= cmd_q.in_strip ? ram_rdata : '0;
      out_in_q    <= cmd_q.in_strip;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_color = out_color_q;
  assign out_o.in_strip    = out_in_q;

  `SSR_ASSERT(a_clear_blocks_pop, (state_q == ST_CLEAR) |-> !pop_o)
  `SSR_ASSERT(a_write_in_range, ram_we |-> (int'(ram_waddr) < STORE_DEPTH))
  `SSR_ASSERT(a_result_from_read, $rose(out_valid_q) |-> $past(state_q == ST_RDATA))
  `SSR_ASSERT_NEVER(a_no_write_when_idle, ram_we && (state_q == ST_IDLE))

endmodule

`default_nettype wire
